FILE: src/gbnsr_pkg.sv
// Package: shared types and codes for the go-back-N strided read sender.
`timescale 1ns / 1ps

package gbnsr_pkg;

    // Event codes carried in the mode field
    localparam logic [2:0] MODE_START  = 3'd0;
    localparam logic [2:0] MODE_ACK    = 3'd1;
    localparam logic [2:0] MODE_SLOT   = 3'd2;
    localparam logic [2:0] MODE_TICK   = 3'd3;
    localparam logic [2:0] MODE_CANCEL = 3'd4;
    localparam logic [2:0] MODE_DISC   = 3'd5;

    // Result action codes
    localparam logic [2:0] ACT_ACCEPT = 3'd0;
    localparam logic [2:0] ACT_REFUSE = 3'd1;
    localparam logic [2:0] ACT_DATA   = 3'd2;
    localparam logic [2:0] ACT_END    = 3'd3;
    localparam logic [2:0] ACT_DONE   = 3'd4;
    localparam logic [2:0] ACT_ABORT  = 3'd5;

    // Configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W   = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 8'd1;
    localparam logic [7:0]  WINDOW_RESET  = 8'd8;
    localparam logic [15:0] TIMEOUT_RESET = 16'd200;

    // Input word
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] start_frame;
        logic [31:0] stride_minus_one;
        logic [7:0]  ack_seq;
        logic        at_end;
        logic        storage_ok;
    } gbnsr_in_t;

    // Result word
    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  seq;
        logic [31:0] byte_pos;
    } gbnsr_out_t;

    // Input word after byte scaling, held in the input register
    typedef struct packed {
        logic [2:0]  mode;
        logic [31:0] start_pos;
        logic [31:0] stride_bytes;
        logic [7:0]  ack_seq;
        logic        at_end;
        logic        storage_ok;
    } gbnsr_item_t;

    // Result handed from the control logic to the output register
    typedef struct packed {
        logic       valid;
        gbnsr_out_t word;
    } gbnsr_res_t;

endpackage

FILE: src/gbnsr_ctrl.sv
// Sender state and per-event update logic for the go-back-N strided read sender.
`timescale 1ns / 1ps

module gbnsr_ctrl
    import gbnsr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        step_en,
    input  gbnsr_item_t item,
    input  logic [7:0]  window_frames,
    input  logic [15:0] timeout_ticks,
    output gbnsr_res_t  result
);

    logic        active_reg,         active_next;
    logic [31:0] next_send_reg,      next_send_next;
    logic [31:0] oldest_unacked_reg, oldest_unacked_next;
    logic [31:0] end_frame_reg,      end_frame_next;
    logic        end_known_reg,      end_known_next;
    logic [31:0] send_pos_reg,       send_pos_next;
    logic [31:0] ack_pos_reg,        ack_pos_next;
    logic [31:0] stride_bytes_reg,   stride_bytes_next;
    logic [15:0] ticks_left_reg,     ticks_left_next;

    logic [31:0] in_flight;
    logic [31:0] oldest_inc;
    logic [31:0] next_inc;

    assign in_flight  = next_send_reg - oldest_unacked_reg;
    assign oldest_inc = oldest_unacked_reg + 32'd1;
    assign next_inc   = next_send_reg + 32'd1;

    // Decode one event into the next state and an optional result
    always_comb begin
        active_next         = active_reg;
        next_send_next      = next_send_reg;
        oldest_unacked_next = oldest_unacked_reg;
        end_frame_next      = end_frame_reg;
        end_known_next      = end_known_reg;
        send_pos_next       = send_pos_reg;
        ack_pos_next        = ack_pos_reg;
        stride_bytes_next   = stride_bytes_reg;
        ticks_left_next     = ticks_left_reg;
        result              = '0;

        case (item.mode)
            MODE_START: begin
                if (!active_reg) begin
                    result.valid = 1'b1;
                    if (!item.storage_ok) begin
                        result.word.action = ACT_REFUSE;
                    end else begin
                        active_next         = 1'b1;
                        next_send_next      = '0;
                        oldest_unacked_next = '0;
                        end_frame_next      = '0;
                        end_known_next      = 1'b0;
                        ack_pos_next        = item.start_pos;
                        send_pos_next       = item.start_pos;
                        stride_bytes_next   = item.stride_bytes;
                        ticks_left_next     = timeout_ticks;
                        result.word.action   = ACT_ACCEPT;
                        result.word.byte_pos = item.start_pos;
                    end
                end
            end
            MODE_ACK: begin
                // Match acks in order against the oldest outstanding frame
                if (active_reg && oldest_unacked_reg != next_send_reg
                        && item.ack_seq == oldest_unacked_reg[7:0]) begin
                    oldest_unacked_next = oldest_inc;
                    ack_pos_next        = ack_pos_reg + stride_bytes_reg;
                    ticks_left_next     = timeout_ticks;
                    if (end_known_reg && oldest_inc == end_frame_reg) begin
                        active_next        = 1'b0;
                        result.valid       = 1'b1;
                        result.word.action = ACT_DONE;
                    end
                end
            end
            MODE_SLOT: begin
                // Send only while the window has room and the end frame is not out
                if (active_reg && in_flight < {24'd0, window_frames}
                        && !(end_known_reg && next_send_reg == end_frame_reg)) begin
                    result.valid = 1'b1;
                    if (item.at_end) begin
                        next_send_next       = next_inc;
                        send_pos_next        = send_pos_reg + stride_bytes_reg;
                        end_frame_next       = next_inc;
                        end_known_next       = 1'b1;
                        result.word.action   = ACT_END;
                        result.word.seq      = next_send_reg[7:0];
                        result.word.byte_pos = send_pos_reg;
                    end else if (!item.storage_ok) begin
                        active_next        = 1'b0;
                        result.word.action = ACT_ABORT;
                    end else begin
                        next_send_next       = next_inc;
                        send_pos_next        = send_pos_reg + stride_bytes_reg;
                        result.word.action   = ACT_DATA;
                        result.word.seq      = next_send_reg[7:0];
                        result.word.byte_pos = send_pos_reg;
                    end
                end
            end
            MODE_TICK: begin
                // Rewind to the oldest unacked frame on timeout, else count down
                if (active_reg) begin
                    if (ticks_left_reg <= 16'd1) begin
                        next_send_next  = oldest_unacked_reg;
                        send_pos_next   = ack_pos_reg;
                        ticks_left_next = timeout_ticks;
                    end else begin
                        ticks_left_next = ticks_left_reg - 16'd1;
                    end
                end
            end
            MODE_CANCEL, MODE_DISC: begin
                if (active_reg) begin
                    active_next        = 1'b0;
                    result.valid       = 1'b1;
                    result.word.action = ACT_ABORT;
                end
            end
            default: begin
            end
        endcase
    end

    // Advance state once per processed event
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg         <= 1'b0;
            next_send_reg      <= '0;
            oldest_unacked_reg <= '0;
            end_frame_reg      <= '0;
            end_known_reg      <= 1'b0;
            send_pos_reg       <= '0;
            ack_pos_reg        <= '0;
            stride_bytes_reg   <= '0;
            ticks_left_reg     <= '0;
        end else if (step_en) begin
            active_reg         <= active_next;
            next_send_reg      <= next_send_next;
            oldest_unacked_reg <= oldest_unacked_next;
            end_frame_reg      <= end_frame_next;
            end_known_reg      <= end_known_next;
            send_pos_reg       <= send_pos_next;
            ack_pos_reg        <= ack_pos_next;
            stride_bytes_reg   <= stride_bytes_next;
            ticks_left_reg     <= ticks_left_next;
        end
    end

endmodule

FILE: src/go_back_n_strided_read_sender_core.sv
// Top level: go-back-N strided read sender with input and result registers.
// Data path: a word accepted on s_ is held in the input register; its result is then
// registered in the result register and offered on m_ (input reg, then result reg).
// Throughput: one input word per cycle while m_ready is high; a stalled result blocks
// new words only when the held word also gives a result. Silent words never wait on m_ready.
// Reset: aresetn low clears the sender state and both valid flags and restores
// window_frames to 8 and timeout_ticks to 200.
`timescale 1ns / 1ps

module go_back_n_strided_read_sender_core
    import gbnsr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 242
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  gbnsr_in_t             s_word,
    output logic                  m_valid,
    input  logic                  m_ready,
    output gbnsr_out_t            m_word,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [31:0] FRAME_BYTES_W = 32'(FRAME_BYTES);

    logic        in_valid_reg;
    gbnsr_item_t in_item_reg;
    gbnsr_item_t in_item_next;
    logic        m_valid_reg;
    gbnsr_out_t  m_word_reg;
    logic [7:0]  window_frames_reg;
    logic [15:0] timeout_ticks_reg;
    gbnsr_res_t  result;
    logic        advance;
    logic        s_fire;

    // Retire the held word when its result, if any, has a place to go
    assign advance = in_valid_reg && (!result.valid || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_fire  = s_valid && s_ready;

    // Scale frame counts to byte positions on the way in
    always_comb begin
        in_item_next.mode         = s_word.mode;
        in_item_next.start_pos    = s_word.start_frame * FRAME_BYTES_W;
        in_item_next.stride_bytes = s_word.stride_minus_one * FRAME_BYTES_W + FRAME_BYTES_W;
        in_item_next.ack_seq      = s_word.ack_seq;
        in_item_next.at_end       = s_word.at_end;
        in_item_next.storage_ok   = s_word.storage_ok;
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_fire) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
        if (s_fire) begin
            in_item_reg <= in_item_next;
        end
    end

    gbnsr_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (advance),
        .item          (in_item_reg),
        .window_frames (window_frames_reg),
        .timeout_ticks (timeout_ticks_reg),
        .result        (result)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance && result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (advance && result.valid) begin
            m_word_reg <= result.word;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_word  = m_word_reg;

    // Configuration registers; writes beyond the list are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_frames_reg <= WINDOW_RESET;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_WINDOW:  window_frames_reg <= cfg_data[7:0];
                CFG_TIMEOUT: timeout_ticks_reg <= cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

endmodule

FILE: src/gbnsr_checker.sv
// Port-level checker for the go-back-N strided read sender, with its bind.
`timescale 1ns / 1ps

module gbnsr_checker
    import gbnsr_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input gbnsr_out_t m_word
);

    // Result register comes out of reset empty
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // A stalled result stays offered
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its word
    a_hold_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_word))
        else $error("result word changed while stalled");

    // Refuse, finish and abort carry no sequence or position
    a_zero_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_word.action == ACT_REFUSE || m_word.action == ACT_DONE
                    || m_word.action == ACT_ABORT)
        |-> m_word.seq == 8'd0 && m_word.byte_pos == 32'd0)
        else $error("nonzero fields on a control result");

    // Start accepted carries sequence zero
    a_accept_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.action == ACT_ACCEPT |-> m_word.seq == 8'd0)
        else $error("start accepted with nonzero sequence");

endmodule

bind go_back_n_strided_read_sender_core gbnsr_checker u_gbnsr_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);

FILE: tb/sv/gbnsr_sender_checker.sv
// Checker: tracks the sender state from observed words and compares every result word.
`timescale 1ns / 1ps

module gbnsr_sender_checker
    import gbnsr_pkg::*;
#(
    parameter int unsigned FRAME_BYTES = 242
)
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  gbnsr_in_t             s_word,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  gbnsr_out_t            m_word,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           mismatches,
    output int unsigned           outstanding,
    output logic                  xfer_open,
    output logic [7:0]            oldest_seq
);

    localparam logic [31:0] FRAME_SCALE = FRAME_BYTES;

    // Register copies
    logic [7:0]  window_reg;
    logic [15:0] timeout_reg;

    // Transfer state
    logic        in_transfer;
    logic [31:0] next_frame;
    logic [31:0] oldest_frame;
    logic [31:0] end_frame_idx;
    logic        end_sent;
    logic [31:0] send_byte;
    logic [31:0] ack_byte;
    logic [31:0] stride_step;
    logic [15:0] tick_budget;

    // Result words still owed by the block, oldest first
    gbnsr_out_t expected_results[$];

    // Apply one accepted word to the transfer state and queue the word it owes, if any
    task automatic predict_event(input gbnsr_in_t w);
        logic [31:0] in_flight;
        gbnsr_out_t  r;
        bit          owes_result;
        owes_result = 1'b0;
        r = '0;
        in_flight = next_frame - oldest_frame;
        case (w.mode)
            MODE_START: begin
                // a start during a transfer is dropped
                if (!in_transfer) begin
                    owes_result = 1'b1;
                    if (!w.storage_ok) begin
                        r.action = ACT_REFUSE;
                    end else begin
                        in_transfer   = 1'b1;
                        next_frame    = '0;
                        oldest_frame  = '0;
                        end_frame_idx = '0;
                        end_sent      = 1'b0;
                        ack_byte      = w.start_frame * FRAME_SCALE;
                        send_byte     = ack_byte;
                        stride_step   = (w.stride_minus_one + 32'd1) * FRAME_SCALE;
                        tick_budget   = timeout_reg;
                        r.action      = ACT_ACCEPT;
                        r.byte_pos    = ack_byte;
                    end
                end
            end
            MODE_ACK: begin
                // only an in-order ack of an outstanding frame advances the window
                if (in_transfer && oldest_frame != next_frame &&
                    w.ack_seq == oldest_frame[7:0]) begin
                    oldest_frame += 32'd1;
                    ack_byte     += stride_step;
                    tick_budget   = timeout_reg;
                    if (end_sent && oldest_frame == end_frame_idx) begin
                        in_transfer = 1'b0;
                        owes_result = 1'b1;
                        r.action    = ACT_DONE;
                    end
                end
            end
            MODE_SLOT: begin
                // send only with room in the window and the end frame not yet out
                if (in_transfer && in_flight < 32'(window_reg) &&
                    !(end_sent && next_frame == end_frame_idx)) begin
                    owes_result = 1'b1;
                    if (w.at_end || w.storage_ok) begin
                        r.action   = w.at_end ? ACT_END : ACT_DATA;
                        r.seq      = next_frame[7:0];
                        r.byte_pos = send_byte;
                        next_frame += 32'd1;
                        send_byte  += stride_step;
                        if (w.at_end) begin
                            end_frame_idx = next_frame;
                            end_sent      = 1'b1;
                        end
                    end else begin
                        in_transfer = 1'b0;
                        r.action    = ACT_ABORT;
                    end
                end
            end
            MODE_TICK: begin
                // rewind to the oldest unacked frame once the budget runs out
                if (in_transfer) begin
                    if (tick_budget <= 16'd1) begin
                        next_frame  = oldest_frame;
                        send_byte   = ack_byte;
                        tick_budget = timeout_reg;
                    end else begin
                        tick_budget -= 16'd1;
                    end
                end
            end
            MODE_CANCEL, MODE_DISC: begin
                if (in_transfer) begin
                    in_transfer = 1'b0;
                    owes_result = 1'b1;
                    r.action    = ACT_ABORT;
                end
            end
            default: ;
        endcase
        if (owes_result) begin
            expected_results.push_back(r);
        end
    endtask

    // Sample all channels at the rising edge
    always @(posedge aclk) begin : watch_channels
        gbnsr_out_t got;
        gbnsr_out_t want;
        if (!aresetn) begin
            window_reg    = WINDOW_RESET;
            timeout_reg   = TIMEOUT_RESET;
            in_transfer   = 1'b0;
            next_frame    = '0;
            oldest_frame  = '0;
            end_frame_idx = '0;
            end_sent      = 1'b0;
            send_byte     = '0;
            ack_byte      = '0;
            stride_step   = '0;
            tick_budget   = '0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_WINDOW:  window_reg  = cfg_data[7:0];
                    CFG_TIMEOUT: timeout_reg = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                predict_event(s_word);
            end
            if (m_valid && m_ready) begin
                got = m_word;
                if (expected_results.size() == 0) begin
                    $error("unexpected result word: action %0d seq %0d byte_pos 0x%08h",
                           got.action, got.seq, got.byte_pos);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got.action !== want.action) begin
                        $error("action mismatch: expected %0d, got %0d",
                               want.action, got.action);
                        mismatches++;
                    end
                    if (got.seq !== want.seq) begin
                        $error("seq mismatch: expected %0d, got %0d", want.seq, got.seq);
                        mismatches++;
                    end
                    if (got.byte_pos !== want.byte_pos) begin
                        $error("byte_pos mismatch: expected 0x%08h, got 0x%08h",
                               want.byte_pos, got.byte_pos);
                        mismatches++;
                    end
                end
            end
        end
        outstanding = expected_results.size();
        xfer_open   = in_transfer;
        oldest_seq  = oldest_frame[7:0];
    end

endmodule

FILE: tb/sv/tb_go_back_n_strided_read_sender_core.sv
// Testbench top: drives events and register writes into the sender and gives the verdict.
`timescale 1ns / 1ps

module tb_go_back_n_strided_read_sender_core;
    import gbnsr_pkg::*;

    localparam int unsigned FRAME_BYTES    = 242;
    localparam logic [2:0]  MODE_UNUSED_6  = 3'd6;
    localparam logic [2:0]  MODE_UNUSED_7  = 3'd7;
    localparam int unsigned IDLE_PCT       = 35;
    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 8;
    localparam int unsigned STALL_LIMIT    = 3000;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    gbnsr_in_t             s_word    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    gbnsr_out_t            m_word;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned mismatches;
    int unsigned outstanding;
    logic        xfer_open;
    logic [7:0]  oldest_seq;

    // no idling on either side while set; one long receiver hold once requested
    bit          steady   = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned quiet_cycles = 0;

    always #6 aclk = ~aclk;

    go_back_n_strided_read_sender_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    gbnsr_sender_checker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) i_checker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .xfer_open   (xfer_open),
        .oldest_seq  (oldest_seq)
    );

    // End the run when no channel moves for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result receiver: random stalls, one long hold when requested
    initial begin : receiver
        bit hold_taken;
        hold_taken = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                m_ready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge aclk);
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    function automatic gbnsr_in_t event_word(input logic [2:0] mode, input logic [31:0] first,
                                             input logic [31:0] skip, input logic [7:0] ack,
                                             input logic at_end, input logic ok);
        gbnsr_in_t w;
        w.mode             = mode;
        w.start_frame      = first;
        w.stride_minus_one = skip;
        w.ack_seq          = ack;
        w.at_end           = at_end;
        w.storage_ok       = ok;
        return w;
    endfunction

    // Random content in every field; small strides are most common
    function automatic gbnsr_in_t random_word();
        gbnsr_in_t w;
        w.mode             = 3'($urandom_range(7));
        w.start_frame      = $urandom;
        w.stride_minus_one = ($urandom_range(9) < 7) ? 32'($urandom_range(3)) : $urandom;
        w.ack_seq          = 8'($urandom);
        w.at_end           = 1'($urandom);
        w.storage_ok       = 1'($urandom);
        return w;
    endfunction

    // Offer one word; call at a falling edge, returns at the accepting rising edge
    task automatic push_word(input gbnsr_in_t w);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // Drop valid, wait for every owed result, then let silent words retire
    task automatic wait_until_quiet(input int unsigned extra);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed transfers: start when idle, then slots, in-order acks and ticks
    task automatic run_traffic(input int unsigned n_items);
        gbnsr_in_t   w;
        int unsigned pick;
        repeat (n_items) begin
            @(negedge aclk);
            w = random_word();
            pick = $urandom_range(99);
            if (!xfer_open) begin
                if (pick < 85) begin
                    w.mode       = MODE_START;
                    w.storage_ok = ($urandom_range(9) != 0);
                end
            end else if (pick < 45) begin
                w.mode       = MODE_SLOT;
                w.at_end     = ($urandom_range(29) == 0);
                w.storage_ok = ($urandom_range(59) != 0);
            end else if (pick < 80) begin
                w.mode = MODE_ACK;
                if ($urandom_range(9) < 8) begin
                    w.ack_seq = oldest_seq;
                end
            end else if (pick < 94) begin
                w.mode = MODE_TICK;
            end else if (pick < 96) begin
                w.mode = ($urandom_range(1) == 0) ? MODE_CANCEL : MODE_DISC;
            end else begin
                // start during a transfer and unused modes are dropped by the block
                w.mode = ($urandom_range(2) == 0) ? MODE_START :
                         ($urandom_range(1) == 0) ? MODE_UNUSED_6 : MODE_UNUSED_7;
            end
            push_word(w);
        end
    endtask

    initial begin : stimulus
        gbnsr_in_t directed[$];

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Narrow window and short timeout so the directed events hit every case
        write_reg(CFG_WINDOW, 16'd2);
        write_reg(CFG_TIMEOUT, 16'd2);

        // events while idle change nothing
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_TICK, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_CANCEL, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_DISC, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_UNUSED_6, '1, '1, 8'hff, 1'b1, 1'b1));
        directed.push_back(event_word(MODE_UNUSED_7, '1, '1, 8'hff, 1'b1, 1'b1));
        // refused start, then a start at the top of the frame range with a wrapping stride
        directed.push_back(event_word(MODE_START, '1, '1, 8'hff, 1'b1, 1'b0));
        directed.push_back(event_word(MODE_START, '1, '1, 8'h00, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_START, 32'd5, 32'd1, 8'h00, 1'b0, 1'b1));
        // fill the window, then one slot too many
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b1));
        // wrong ack byte, then the right one
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'hff, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'h00, 1'b0, 1'b1));
        // count down, then time out and resend
        directed.push_back(event_word(MODE_TICK, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_TICK, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b1));
        // ack the resent frame, then ack with nothing outstanding
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'h01, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'h02, 1'b0, 1'b1));
        // end of file, a slot after the end frame, then finish on its ack
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b1, 1'b0));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b1, 1'b1));
        directed.push_back(event_word(MODE_ACK, '0, '0, 8'h02, 1'b0, 1'b1));
        // read error, cancel and disconnect each abort
        directed.push_back(event_word(MODE_START, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_SLOT, '0, '0, 8'd0, 1'b0, 1'b0));
        directed.push_back(event_word(MODE_START, 32'd7, 32'd2, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_CANCEL, '0, '0, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_START, 32'd9, 32'd3, 8'd0, 1'b0, 1'b1));
        directed.push_back(event_word(MODE_DISC, '0, '0, 8'd0, 1'b0, 1'b1));

        foreach (directed[i]) begin
            @(negedge aclk);
            push_word(directed[i]);
        end
        wait_until_quiet(SETTLE_CYCLES);

        // Widest window, no timeouts; hold the receiver so the block backs up
        write_reg(CFG_WINDOW, 16'd255);
        write_reg(CFG_TIMEOUT, 16'hffff);
        hold_req = 1'b1;
        run_traffic(170);
        wait_until_quiet(SETTLE_CYCLES);

        // Single-frame window, rewind on every tick
        write_reg(CFG_WINDOW, 16'd1);
        write_reg(CFG_TIMEOUT, 16'd1);
        run_traffic(160);
        wait_until_quiet(SETTLE_CYCLES);

        // Mid settings, first part with no idling at all
        write_reg(CFG_WINDOW, 16'd4);
        write_reg(CFG_TIMEOUT, 16'd6);
        steady = 1'b1;
        run_traffic(80);
        steady = 1'b0;
        run_traffic(80);
        wait_until_quiet(SETTLE_CYCLES);

        // Random settings
        write_reg(CFG_WINDOW, 16'($urandom_range(255, 1)));
        write_reg(CFG_TIMEOUT, 16'($urandom_range(40, 2)));
        run_traffic(160);

        wait_until_quiet(TAIL_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
